// ===== rtl/core/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants of the radio packet framer
// Frame constants, byte positions within a frame, queue sizing and the
// command word passed from the front part to the back part.
// ----------------------------------------------------------------------------
package rpf_pkg;

  // payload size of one frame, 1 to 243
  localparam int unsigned PAYLOAD_BYTES = 32;
  localparam logic [7:0]  LAST_POS      = 8'(PAYLOAD_BYTES - 1);

  localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
  localparam logic [7:0] SYNC_BYTE     = 8'h2D;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // byte positions within the frame sequence of one command
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_PRE0   = 4'd0;
  localparam logic [POS_W-1:0] POS_PRE1   = 4'd1;
  localparam logic [POS_W-1:0] POS_PRE2   = 4'd2;
  localparam logic [POS_W-1:0] POS_SYNC   = 4'd3;
  localparam logic [POS_W-1:0] POS_GROUP  = 4'd4;
  localparam logic [POS_W-1:0] POS_SOURCE = 4'd5;
  localparam logic [POS_W-1:0] POS_DEST   = 4'd6;
  localparam logic [POS_W-1:0] POS_DATA   = 4'd7;
  localparam logic [POS_W-1:0] POS_SUM_HI = 4'd8;
  localparam logic [POS_W-1:0] POS_SUM_LO = 4'd9;
  localparam logic [POS_W-1:0] POS_TRL0   = 4'd10;
  localparam logic [POS_W-1:0] POS_TRL1   = 4'd11;
  localparam logic [POS_W-1:0] POS_TRL2   = 4'd12;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_GROUP_ID  = 2'd0,
    REG_SOURCE_ID = 2'd1,
    REG_DEST_ID   = 2'd2
  } rpf_reg_t;

  typedef struct packed {
    logic [7:0] group_id;
    logic [7:0] source_id;
    logic [7:0] dest_id;
  } rpf_cfg_t;

  // one classified payload word
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  group_id;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [15:0] sum;
  } rpf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rpf_qstat_t;

endpackage

// ===== rtl/core/rpf_front.sv =====
// ----------------------------------------------------------------------------
// rpf_front: payload intake
// Tracks the position within the frame, keeps the running sum and pushes
// one classified command per accepted payload word.
// ----------------------------------------------------------------------------
module rpf_front (
  input  logic                clk,
  input  logic                rst,
  input  rpf_pkg::rpf_cfg_t   cfg,
  input  logic                payload_valid,
  input  logic [7:0]          payload_byte,
  output logic                payload_stall,
  input  rpf_pkg::rpf_qstat_t qstat,
  output logic                push,
  output rpf_pkg::rpf_cmd_t   cmd
);
  import rpf_pkg::*;

  logic [7:0]  position;
  logic [15:0] running_sum;
  logic [15:0] sum_base;
  logic [15:0] sum_next;
  logic        is_first;
  logic        is_last;

  always_comb begin
    is_first      = (position == 8'd0);
    is_last       = (position == LAST_POS);
    // source and dest ids seed the sum at the first word
    sum_base      = is_first ? ({8'd0, cfg.source_id} + {8'd0, cfg.dest_id}) : running_sum;
    sum_next      = sum_base + {8'd0, payload_byte};
    payload_stall = qstat.full;
    push          = payload_valid && !qstat.full;
    cmd.first     = is_first;
    cmd.last      = is_last;
    cmd.data      = payload_byte;
    cmd.group_id  = cfg.group_id;
    cmd.source_id = cfg.source_id;
    cmd.dest_id   = cfg.dest_id;
    cmd.sum       = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= 8'd0;
      running_sum <= 16'd0;
    end else if (push) begin
      if (is_last) begin
        position    <= 8'd0;
        running_sum <= 16'd0;
      end else begin
        position    <= position + 8'd1;
        running_sum <= sum_next;
      end
    end
  end

endmodule

// ===== rtl/core/rpf_queue.sv =====
// ----------------------------------------------------------------------------
// rpf_queue: command queue
// Small register queue that decouples payload intake from frame output.
// ----------------------------------------------------------------------------
module rpf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rpf_pkg::rpf_cmd_t   push_cmd,
  input  logic                pop,
  output rpf_pkg::rpf_cmd_t   head,
  output rpf_pkg::rpf_qstat_t qstat
);
  import rpf_pkg::*;

  rpf_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_comb begin
    head        = entries[rd_ptr];
    qstat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
    qstat.empty = (count == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rpf_back.sv =====
// ----------------------------------------------------------------------------
// rpf_back: frame output sequencer
// Walks the queue head's byte sequence, one byte per cycle while the queue
// is not empty and the output not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module rpf_back (
  input  logic                clk,
  input  logic                rst,
  input  rpf_pkg::rpf_cmd_t   head,
  input  rpf_pkg::rpf_qstat_t qstat,
  output logic                pop,
  output logic                frame_valid,
  input  logic                frame_stall,
  output logic [7:0]          frame_byte,
  output logic                frame_end
);
  import rpf_pkg::*;

  logic [POS_W-1:0] step;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] end_pos;
  logic [7:0]       byte_sel;
  logic             go;

  always_comb begin
    // words after the first start directly at the data byte
    pos     = head.first ? step : (step + POS_DATA);
    // a one-word frame stops after the data byte
    end_pos = (head.last && !head.first) ? POS_TRL2 : POS_DATA;
    go      = !qstat.empty && (!frame_valid || !frame_stall);
    pop     = go && (pos == end_pos);
    case (pos)
      POS_PRE0, POS_PRE1, POS_PRE2: byte_sel = PREAMBLE_BYTE;
      POS_SYNC:                     byte_sel = SYNC_BYTE;
      POS_GROUP:                    byte_sel = head.group_id;
      POS_SOURCE:                   byte_sel = head.source_id;
      POS_DEST:                     byte_sel = head.dest_id;
      POS_DATA:                     byte_sel = head.data;
      POS_SUM_HI:                   byte_sel = head.sum[15:8];
      POS_SUM_LO:                   byte_sel = head.sum[7:0];
      POS_TRL0, POS_TRL1, POS_TRL2: byte_sel = PREAMBLE_BYTE;
      default:                      byte_sel = PREAMBLE_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (go) begin
        step <= pop ? '0 : (step + 1'b1);
      end
      if (go) begin
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      frame_byte <= byte_sel;
      frame_end  <= (pos == POS_TRL2);
    end
  end

endmodule

// ===== rtl/core/radio_packet_framer.sv =====
// ----------------------------------------------------------------------------
// radio_packet_framer: preamble, sync, header and 16-bit sum framing
// Wraps fixed-size payloads into radio transmit frames, one byte per word.
// ----------------------------------------------------------------------------
// usage
//   payload channel (payload_valid / payload_stall / payload_byte) takes the
//   payload bytes of each packet in order. frame channel (frame_valid /
//   frame_stall / frame_byte / frame_end) gives the frame bytes: AA AA AA 2D,
//   group, source, dest, payload bytes, sum high, sum low, AA AA AA.
//   frame_end marks the last trailer byte. a one-byte payload frame stops
//   after its payload byte (no sum, no trailer).
// data flow
//   an accepted word is written into the command queue; once it is at the
//   queue head, its frame bytes are registered into the output stage.
//   the output stage gives one frame byte per cycle while it is not stalled
//   and the queue is not empty. a frame of two or more payload bytes has
//   PAYLOAD_BYTES + 12 bytes. a 4-entry command queue lets bursts of payload
//   words in while header or trailer bytes go out.
// reset and stall
//   rst (synchronous) empties the queue, restarts at a frame boundary and
//   sets group_id to 212, source_id and dest_id to 0. a stalled frame byte
//   holds; payload_stall rises only when the command queue is full.
// registers (apb, byte address 4*i): 0 group_id, 1 source_id, 2 dest_id
// ----------------------------------------------------------------------------
module radio_packet_framer (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // payload input
  input  logic        payload_valid,
  output logic        payload_stall,
  input  logic [7:0]  payload_byte,
  // frame output
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);
  import rpf_pkg::*;

  rpf_cfg_t   cfg;
  rpf_reg_t   reg_sel;
  logic       cfg_write;
  rpf_cmd_t   push_cmd;
  rpf_cmd_t   head;
  rpf_qstat_t qstat;
  logic       push;
  logic       pop;

  // register file: word index from paddr[3:2]
  assign pready    = 1'b1;
  assign reg_sel   = rpf_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_GROUP_ID:  prdata = {24'd0, cfg.group_id};
      REG_SOURCE_ID: prdata = {24'd0, cfg.source_id};
      REG_DEST_ID:   prdata = {24'd0, cfg.dest_id};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_id  <= 8'd212;
      cfg.source_id <= 8'd0;
      cfg.dest_id   <= 8'd0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_GROUP_ID:  cfg.group_id  <= pwdata[7:0];
        REG_SOURCE_ID: cfg.source_id <= pwdata[7:0];
        REG_DEST_ID:   cfg.dest_id   <= pwdata[7:0];
        default:       ;  // unmapped address, write dropped
      endcase
    end
  end

  // front: classify payload words, carry position and running sum
  rpf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .payload_stall (payload_stall),
    .qstat         (qstat),
    .push          (push),
    .cmd           (push_cmd)
  );

  // command queue between front and back
  rpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // back: expand each command into its frame bytes
  rpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end)
  );

`ifndef SYNTHESIS
  // a byte marked by frame_end always carries the trailer value
  a_end_is_trailer: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_end |-> frame_byte == PREAMBLE_BYTE)
    else $error("frame_end on a non-trailer byte");

  // queue status flags never both set
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty");

  // a word pushed into an empty queue is visible to the back next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    push && qstat.empty |=> !qstat.empty)
    else $error("pushed word lost");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== dv/tb_radio_packet_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radio_packet_framer: self-checking bench for the radio packet framer
// Drives payload bytes in random bursts and programs group, source and dest
// ids over the register port. A built-in frame predictor produces the expected
// preamble, header, payload, sum and trailer words. Each frame word is checked
// as it is taken, while the output side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_radio_packet_framer;
  import rpf_pkg::*;

  // one payload byte yields at most this many frame words
  localparam int unsigned MAX_FRAME_WORDS = 8;
  // register index past the end of the map, writes there must do nothing
  localparam logic [1:0]  REG_SPARE_IDX   = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_PHASES   = 6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        payload_valid;
  logic        payload_stall;
  logic [7:0]  payload_byte;
  logic        frame_valid;
  logic        frame_stall;
  logic [7:0]  frame_byte;
  logic        frame_end;

  // predictor state: register shadow, payload position and running sum
  rpf_cfg_t    cfg_shadow;
  logic [7:0]  pay_pos;
  logic [15:0] frame_sum;
  frame_word_t frame_exp_q[$];
  frame_word_t exp_word;

  int errors;
  int words_sent;
  int words_checked;
  int frames_closed;
  int settings_used;
  int burst_left;

  radio_packet_framer u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .payload_valid (payload_valid),
    .payload_stall (payload_stall),
    .payload_byte  (payload_byte),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .frame_byte    (frame_byte),
    .frame_end     (frame_end)
  );

  // 125 MHz clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d frame words still owed",
             $time, CYCLE_LIMIT, frame_exp_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic frame_word_t fw(input logic [7:0] d, input logic l);
    frame_word_t w;
    w.data = d;
    w.last = l;
    return w;
  endfunction

  // frame words caused by one accepted payload byte
  task automatic predict_frame_words(input logic [7:0] b);
    frame_word_t seq[$];
    // frame start: preamble, sync and header, ids captured here
    if (pay_pos == 8'd0) begin
      seq.push_back(fw(PREAMBLE_BYTE, 1'b0));
      seq.push_back(fw(PREAMBLE_BYTE, 1'b0));
      seq.push_back(fw(PREAMBLE_BYTE, 1'b0));
      seq.push_back(fw(SYNC_BYTE, 1'b0));
      seq.push_back(fw(cfg_shadow.group_id, 1'b0));
      seq.push_back(fw(cfg_shadow.source_id, 1'b0));
      seq.push_back(fw(cfg_shadow.dest_id, 1'b0));
      frame_sum = 16'(cfg_shadow.source_id) + 16'(cfg_shadow.dest_id);
    end
    seq.push_back(fw(b, 1'b0));
    frame_sum = frame_sum + 16'(b);
    // last payload byte closes the frame with sum and trailer
    if (int'(pay_pos) + 1 >= int'(PAYLOAD_BYTES)) begin
      seq.push_back(fw(frame_sum[15:8], 1'b0));
      seq.push_back(fw(frame_sum[7:0], 1'b0));
      seq.push_back(fw(PREAMBLE_BYTE, 1'b0));
      seq.push_back(fw(PREAMBLE_BYTE, 1'b0));
      seq.push_back(fw(PREAMBLE_BYTE, 1'b1));
      pay_pos   = 8'd0;
      frame_sum = 16'd0;
      frames_closed++;
    end else begin
      pay_pos = pay_pos + 8'd1;
    end
    // a one-byte frame drops whatever does not fit in one step
    for (int i = 0; i < seq.size() && i < int'(MAX_FRAME_WORDS); i++)
      frame_exp_q.push_back(seq[i]);
  endtask

  // frame word checker, runs for the whole test
  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) begin
      if (frame_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame word: expected none, actual byte %02h end %0b",
                 $time, frame_byte, frame_end);
      end else begin
        exp_word = frame_exp_q.pop_front();
        words_checked++;
        if (frame_byte !== exp_word.data) begin
          errors++;
          $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                   $time, exp_word.data, frame_byte);
        end
        if (frame_end !== exp_word.last) begin
          errors++;
          $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                   $time, exp_word.last, frame_end);
        end
      end
    end
  end

  // output backpressure: a random pattern, held for a random span, then another
  initial begin
    int mode;
    int span;
    frame_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(16, 120);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: frame_stall <= 1'b0;                          // free running
          1: frame_stall <= ($urandom_range(0, 2) == 0);   // random, light
          2: frame_stall <= (c % 4 == 3);                  // periodic
          3: frame_stall <= ($urandom_range(0, 3) != 0);   // random, heavy
          default: frame_stall <= (c % 24 < 12);           // long holds
        endcase
      end
    end
  end

  // sender pacing: random bursts with random gaps, some long bursts
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      payload_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 6);
    end
  endtask

  // one payload word through the handshake, then predict its frame words
  task automatic send_payload(input logic [7:0] b);
    @(negedge clk);
    payload_valid <= 1'b1;
    payload_byte  <= b;
    @(posedge clk);
    while (payload_stall) @(posedge clk);
    predict_frame_words(b);
    words_sent++;
    pace_sender();
  endtask

  // stop sending and wait for every owed frame word
  task automatic drain();
    @(negedge clk);
    payload_valid <= 1'b0;
    while (frame_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GROUP_ID:  cfg_shadow.group_id  = value;
      REG_SOURCE_ID: cfg_shadow.source_id = value;
      REG_DEST_ID:   cfg_shadow.dest_id   = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(input rpf_reg_t idx);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GROUP_ID:  want = {24'h0, cfg_shadow.group_id};
      REG_SOURCE_ID: want = {24'h0, cfg_shadow.source_id};
      default:       want = {24'h0, cfg_shadow.dest_id};
    endcase
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %s readback: expected %08h, actual %08h",
               $time, idx.name(), want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    reg_read_check(REG_GROUP_ID);
    reg_read_check(REG_SOURCE_ID);
    reg_read_check(REG_DEST_ID);
  endtask

  task automatic program_ids(input logic [7:0] g, input logic [7:0] s,
                             input logic [7:0] d);
    reg_write(REG_GROUP_ID, g);
    reg_write(REG_SOURCE_ID, s);
    reg_write(REG_DEST_ID, d);
    settings_used++;
  endtask

  // reset values, then a write past the register map must change nothing
  task automatic test_register_reset();
    check_all_regs();
    reg_write(REG_SPARE_IDX, 8'h5A);
    check_all_regs();
  endtask

  // one full frame of extreme bytes, ids changed halfway through the frame
  task automatic test_directed_frame();
    logic [7:0] pattern [16];
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                8'h2D, 8'hD2, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'hFF, 8'hFF};
    burst_left = 0;
    for (int i = 0; i < 16; i++)
      send_payload(pattern[i]);
    // mid-frame register update: header and sum of this frame keep old ids
    drain();
    program_ids(8'hFF, 8'hFF, 8'hFF);
    reg_write(REG_SPARE_IDX, 8'h00);
    check_all_regs();
    // second half: inverted pattern, then top off to the frame end
    for (int i = 0; i < 16; i++)
      send_payload(~pattern[i]);
    while (pay_pos != 8'd0)
      send_payload(8'hFF);
    drain();
  endtask

  // random payload streams over several id settings, extremes first
  task automatic test_random_traffic();
    int count;
    int kind;
    logic [7:0] b;
    for (int p = 0; p < int'(RANDOM_PHASES); p++) begin
      drain();
      case (p)
        0: program_ids(8'h00, 8'h00, 8'h00);
        1: program_ids(8'hFF, 8'hFF, 8'hFF);
        2: program_ids(8'h00, 8'hFF, 8'h00);
        default: program_ids(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      check_all_regs();
      count = $urandom_range(50, 80);
      for (int i = 0; i < count; i++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = PREAMBLE_BYTE;    // looks like framing on the line
          3: b = SYNC_BYTE;
          default: b = 8'($urandom);
        endcase
        send_payload(b);
      end
    end
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    payload_valid = 1'b0;
    payload_byte  = '0;
    cfg_shadow    = '{group_id: 8'd212, source_id: 8'd0, dest_id: 8'd0};
    pay_pos       = 8'd0;
    frame_sum     = 16'd0;
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    frames_closed = 0;
    settings_used = 0;
    burst_left    = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_directed_frame();
    test_random_traffic();
    drain();

    $display("covered %0d payload bytes, %0d frame words checked, %0d frames closed",
             words_sent, words_checked, frames_closed);
    $display("over %0d id settings, with mid-frame and out-of-map register writes",
             settings_used);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rpf_pkg.sv
rtl/core/rpf_front.sv
rtl/core/rpf_queue.sv
rtl/core/rpf_back.sv
rtl/core/radio_packet_framer.sv
dv/tb_radio_packet_framer.sv
